// File: hw/rtl/gbk_pkg.sv
package gbk_pkg;

    // Byte classes of the GBK stream
    localparam logic [7:0] LEAD_LOW   = 8'h81;
    localparam logic [7:0] LEAD_HIGH  = 8'hFE;
    localparam logic [7:0] TRAIL_LOW  = 8'h40;
    localparam logic [7:0] TRAIL_HIGH = 8'hFE;

    localparam logic [15:0] PASS_MAX      = 16'h007F;
    localparam logic [15:0] REPLACEMENT   = 16'hFFFD;
    localparam logic [15:0] ENTRIES_RESET = 16'd21920;

    // Register index, taken from the word address of the configuration port
    localparam logic REG_ENTRIES = 1'b0;

    // Kind of an input request
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    typedef struct packed {
        logic        start;
        logic [15:0] code;
    } search_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] code_point;
        logic        found;
    } search_rsp_t;

endpackage

// File: hw/rtl/gbk_table_ram.sv
module gbk_table_ram #(
    parameter int unsigned DEPTH = 32768,
    parameter int unsigned AW    = 15
) (
    input  logic          aclk,
    input  logic          wr_en_i,
    input  logic [AW-1:0] wr_addr_i,
    input  logic [31:0]   wr_data_i,
    input  logic          rd_en_i,
    input  logic [AW-1:0] rd_addr_i,
    output logic [31:0]   rd_data_o
);

    // Each word holds key in the upper half and code point in the lower half
    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en_i) begin
            mem[wr_addr_i] <= wr_data_i;
        end
        if (rd_en_i) begin
            rd_data_reg <= mem[rd_addr_i];
        end
    end

    assign rd_data_o = rd_data_reg;

endmodule

// File: hw/rtl/gbk_search.sv
module gbk_search #(
    parameter int unsigned TABLE_DEPTH = 32768,
    parameter int unsigned AW          = 15
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [15:0]          entries_i,
    input  gbk_pkg::search_req_t req_i,
    output gbk_pkg::search_rsp_t rsp_o,
    output logic                 rd_en_o,
    output logic [AW-1:0]        rd_addr_o,
    input  logic [31:0]          rd_data_i
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_CMP  = 2'b10
    } srch_state_t;

    localparam logic [16:0] DEPTH_W = 17'(TABLE_DEPTH);

    srch_state_t st_reg, st_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [AW-1:0] mid_reg, mid_next;
    logic [15:0]   code_reg, code_next;
    logic          done_reg, done_next;
    logic [15:0]   cp_reg, cp_next;
    logic          found_reg, found_next;

    logic [16:0] ent_w;
    logic [16:0] span_w;
    logic [16:0] top_w;
    logic [AW-1:0] mid0;
    logic [AW-1:0] hi0;
    logic [AW:0]   sum_up;
    logic [AW:0]   sum_dn;
    logic [AW-1:0] mid_up;
    logic [AW-1:0] mid_dn;
    logic [15:0]   key;

    assign ent_w  = {1'b0, entries_i};
    assign span_w = (ent_w > DEPTH_W) ? DEPTH_W : ent_w;
    assign top_w  = span_w - 17'd1;
    assign hi0    = top_w[AW-1:0];
    assign mid0   = top_w[AW:1];

    // Both candidate midpoints are ready before the compare picks one
    assign sum_up = {1'b0, mid_reg} + {1'b0, hi_reg} + {{AW{1'b0}}, 1'b1};
    assign sum_dn = {1'b0, lo_reg} + {1'b0, mid_reg} - {{AW{1'b0}}, 1'b1};
    assign mid_up = sum_up[AW:1];
    assign mid_dn = sum_dn[AW:1];
    assign key    = rd_data_i[31:16];

    always_comb begin
        st_next    = st_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        code_next  = code_reg;
        done_next  = 1'b0;
        cp_next    = cp_reg;
        found_next = found_reg;
        rd_en_o    = 1'b0;
        rd_addr_o  = mid_reg;
        case (st_reg)
            S_IDLE: begin
                if (req_i.start) begin
                    code_next = req_i.code;
                    if (span_w == 17'd0) begin
                        done_next  = 1'b1;
                        cp_next    = gbk_pkg::REPLACEMENT;
                        found_next = 1'b0;
                    end else begin
                        lo_next   = '0;
                        hi_next   = hi0;
                        mid_next  = mid0;
                        rd_en_o   = 1'b1;
                        rd_addr_o = mid0;
                        st_next   = S_CMP;
                    end
                end
            end
            S_CMP: begin
                if (key == code_reg) begin
                    done_next  = 1'b1;
                    cp_next    = rd_data_i[15:0];
                    found_next = 1'b1;
                    st_next    = S_IDLE;
                end else if (key < code_reg && mid_reg < hi_reg) begin
                    lo_next   = mid_reg + AW'(1);
                    mid_next  = mid_up;
                    rd_en_o   = 1'b1;
                    rd_addr_o = mid_up;
                end else if (key > code_reg && lo_reg < mid_reg) begin
                    hi_next   = mid_reg - AW'(1);
                    mid_next  = mid_dn;
                    rd_en_o   = 1'b1;
                    rd_addr_o = mid_dn;
                end else begin
                    // range exhausted: miss
                    done_next  = 1'b1;
                    cp_next    = gbk_pkg::REPLACEMENT;
                    found_next = 1'b0;
                    st_next    = S_IDLE;
                end
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        code_reg  <= code_next;
        cp_reg    <= cp_next;
        found_reg <= found_next;
    end

    assign rsp_o.done       = done_reg;
    assign rsp_o.code_point = cp_reg;
    assign rsp_o.found      = found_reg;

endmodule

// File: hw/rtl/gbk_to_unicode_stream_decoder.sv
// A passthrough code reaches m_tvalid without a table search; a table code takes k
// binary-search reads first (one per cycle, at most ceil(log2(entries + 1)), up to 16 for
// 32768 entries; k = 0 for 0 entries).
// One request at a time; s_tready stays low until its one or two codes are out, and
// m_tready stalls hold them back.
// Synchronous reset clears decoder state and output, sets entries_in_use to 21920; table undefined.
module gbk_to_unicode_stream_decoder #(
    parameter int unsigned TABLE_DEPTH = 32768
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_index[14:0], entry_key[30:15], entry_value[46:31], data_byte[54:47], zero pad
    input  logic [55:0] s_tdata,
    // mode[0]
    input  logic        s_tuser,
    // end_of_string
    input  logic        s_tlast,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // code_point[15:0]
    output logic [15:0] m_tdata,
    // found[0]
    output logic        m_tuser,
    // last
    output logic        m_tlast
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [16:0] DEPTH_W = 17'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SEL  = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_PUT  = 4'b1000
    } dec_state_t;

    dec_state_t st_reg, st_next;
    logic [15:0] entries_reg, entries_next;
    logic [7:0]  held_reg, held_next;
    logic        pending_reg, pending_next;
    logic        discard_reg, discard_next;
    logic [15:0] cur_code_reg, cur_code_next;
    logic [15:0] nxt_code_reg, nxt_code_next;
    logic        more_reg, more_next;
    logic [15:0] res_cp_reg, res_cp_next;
    logic        res_found_reg, res_found_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_cp_reg, out_cp_next;
    logic        out_found_reg, out_found_next;
    logic        out_last_reg, out_last_next;

    logic        accept;
    logic        cfg_wr;
    logic [14:0] in_index;
    logic [7:0]  in_byte;
    logic        is_lead;
    logic        is_trail;
    logic        ram_we;
    logic        ram_re;
    logic [AW-1:0] ram_ra;
    logic [31:0]   ram_rd;
    gbk_pkg::search_req_t srch_req;
    gbk_pkg::search_rsp_t srch_rsp;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == gbk_pkg::REG_ENTRIES);
    assign prdata = (paddr[2] == gbk_pkg::REG_ENTRIES) ? {16'd0, entries_reg} : 32'd0;

    assign s_tready = (st_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign in_index = s_tdata[14:0];
    assign in_byte  = s_tdata[54:47];
    assign is_lead  = in_byte inside {[gbk_pkg::LEAD_LOW:gbk_pkg::LEAD_HIGH]};
    assign is_trail = in_byte inside {[gbk_pkg::TRAIL_LOW:gbk_pkg::TRAIL_HIGH]};

    // Loads write straight into the table; no search runs while the block is taking requests
    assign ram_we = accept & (s_tuser == gbk_pkg::MODE_LOAD) & ({2'b00, in_index} < DEPTH_W);

    assign srch_req.start = (st_reg == ST_SEL) & (cur_code_reg > gbk_pkg::PASS_MAX);
    assign srch_req.code  = cur_code_reg;

    gbk_table_ram #(
        .DEPTH(TABLE_DEPTH),
        .AW   (AW)
    ) u_table (
        .aclk     (aclk),
        .wr_en_i  (ram_we),
        .wr_addr_i(AW'(in_index)),
        .wr_data_i({s_tdata[30:15], s_tdata[46:31]}),
        .rd_en_i  (ram_re),
        .rd_addr_i(ram_ra),
        .rd_data_o(ram_rd)
    );

    gbk_search #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .AW         (AW)
    ) u_search (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .entries_i(entries_reg),
        .req_i    (srch_req),
        .rsp_o    (srch_rsp),
        .rd_en_o  (ram_re),
        .rd_addr_o(ram_ra),
        .rd_data_i(ram_rd)
    );

    always_comb begin
        st_next        = st_reg;
        entries_next   = entries_reg;
        held_next      = held_reg;
        pending_next   = pending_reg;
        discard_next   = discard_reg;
        cur_code_next  = cur_code_reg;
        nxt_code_next  = nxt_code_reg;
        more_next      = more_reg;
        res_cp_next    = res_cp_reg;
        res_found_next = res_found_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        out_cp_next    = out_cp_reg;
        out_found_next = out_found_reg;
        out_last_next  = out_last_reg;

        if (cfg_wr) begin
            entries_next = pwdata[15:0];
        end

        case (st_reg)
            ST_IDLE: begin
                if (accept && s_tuser == gbk_pkg::MODE_DATA) begin
                    if (discard_reg) begin
                        if (s_tlast) begin
                            discard_next = 1'b0;
                        end
                    end else if (in_byte == 8'd0) begin
                        // flush any held lead, then drop up to end of string
                        if (pending_reg) begin
                            pending_next  = 1'b0;
                            cur_code_next = {8'd0, held_reg};
                            more_next     = 1'b0;
                            st_next       = ST_SEL;
                        end
                        if (!s_tlast) begin
                            discard_next = 1'b1;
                        end
                    end else if (pending_reg && is_trail) begin
                        pending_next  = 1'b0;
                        cur_code_next = {held_reg, in_byte};
                        more_next     = 1'b0;
                        st_next       = ST_SEL;
                    end else if (is_lead && !s_tlast) begin
                        // stale lead goes out alone, new lead is held
                        held_next     = in_byte;
                        pending_next  = 1'b1;
                        cur_code_next = {8'd0, held_reg};
                        more_next     = 1'b0;
                        if (pending_reg) begin
                            st_next = ST_SEL;
                        end
                    end else begin
                        pending_next = 1'b0;
                        more_next    = pending_reg;
                        if (pending_reg) begin
                            cur_code_next = {8'd0, held_reg};
                            nxt_code_next = {8'd0, in_byte};
                        end else begin
                            cur_code_next = {8'd0, in_byte};
                        end
                        st_next = ST_SEL;
                    end
                end
            end
            ST_SEL: begin
                if (cur_code_reg <= gbk_pkg::PASS_MAX) begin
                    res_cp_next    = cur_code_reg;
                    res_found_next = 1'b1;
                    st_next        = ST_PUT;
                end else begin
                    st_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (srch_rsp.done) begin
                    res_cp_next    = srch_rsp.code_point;
                    res_found_next = srch_rsp.found;
                    st_next        = ST_PUT;
                end
            end
            ST_PUT: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_cp_next    = res_cp_reg;
                    out_found_next = res_found_reg;
                    out_last_next  = ~more_reg;
                    if (more_reg) begin
                        cur_code_next = nxt_code_reg;
                        more_next     = 1'b0;
                        st_next       = ST_SEL;
                    end else begin
                        st_next = ST_IDLE;
                    end
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            entries_reg   <= gbk_pkg::ENTRIES_RESET;
            held_reg      <= 8'd0;
            pending_reg   <= 1'b0;
            discard_reg   <= 1'b0;
            more_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg        <= st_next;
            entries_reg   <= entries_next;
            held_reg      <= held_next;
            pending_reg   <= pending_next;
            discard_reg   <= discard_next;
            more_reg      <= more_next;
            out_valid_reg <= out_valid_next;
        end
        cur_code_reg  <= cur_code_next;
        nxt_code_reg  <= nxt_code_next;
        res_cp_reg    <= res_cp_next;
        res_found_reg <= res_found_next;
        out_cp_reg    <= out_cp_next;
        out_found_reg <= out_found_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_cp_reg;
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int unsigned TABLE_DEPTH = 32768;
    localparam logic [2:0]  ENTRIES_ADDR = {gbk_pkg::REG_ENTRIES, 2'b00};
    localparam int unsigned SETTING_COUNT = 8;
    localparam int unsigned ITEMS_PER_SETTING = 225;

    typedef struct packed {
        logic [15:0] code_point;
        logic        found;
        logic        last;
    } decoded_char_t;

    // Tracks the decoder state and the table, and holds the code points still due.
    class code_point_tracker;
        logic [15:0]   keys [TABLE_DEPTH];
        logic [15:0]   values [TABLE_DEPTH];
        int unsigned   search_len = gbk_pkg::ENTRIES_RESET;
        logic [7:0]    lead_byte = 8'h00;
        bit            lead_held = 1'b0;
        bit            skipping = 1'b0;
        decoded_char_t due_chars [$];
        int unsigned   errors = 0;
        int unsigned   live_items = 0;
        int unsigned   checked = 0;
        int unsigned   hits = 0;
        int unsigned   misses = 0;

        function void set_entries(logic [15:0] value);
            search_len = value;
        endfunction

        function decoded_char_t translate(logic [15:0] code);
            decoded_char_t r;
            int lo;
            int hi;
            int mid;
            r.code_point = gbk_pkg::REPLACEMENT;
            r.found = 1'b0;
            r.last = 1'b0;
            if (code <= gbk_pkg::PASS_MAX) begin
                r.code_point = code;
                r.found = 1'b1;
                return r;
            end
            lo = 0;
            hi = int'((search_len > TABLE_DEPTH) ? TABLE_DEPTH : search_len) - 1;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (keys[mid] == code) begin
                    r.code_point = values[mid];
                    r.found = 1'b1;
                    hits++;
                    return r;
                end else if (keys[mid] < code) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
            misses++;
            return r;
        endfunction

        function void accept_request(logic mode, logic [14:0] idx, logic [15:0] key,
                                     logic [15:0] value, logic [7:0] b, logic eos);
            int unsigned before_count;
            bit fresh;
            if (mode == gbk_pkg::MODE_LOAD) begin
                keys[idx] = key;
                values[idx] = value;
                live_items++;
                return;
            end
            // drop everything after a zero byte up to the end of the string
            if (skipping) begin
                if (eos)
                    skipping = 1'b0;
                return;
            end
            live_items++;
            before_count = due_chars.size();
            if (b == 8'h00) begin
                if (lead_held) begin
                    due_chars.push_back(translate({8'h00, lead_byte}));
                    lead_held = 1'b0;
                end
                if (!eos)
                    skipping = 1'b1;
            end else begin
                fresh = 1'b1;
                if (lead_held) begin
                    lead_held = 1'b0;
                    if (b >= gbk_pkg::TRAIL_LOW && b <= gbk_pkg::TRAIL_HIGH) begin
                        due_chars.push_back(translate({lead_byte, b}));
                        fresh = 1'b0;
                    end else begin
                        due_chars.push_back(translate({8'h00, lead_byte}));
                    end
                end
                if (fresh) begin
                    if (b >= gbk_pkg::LEAD_LOW && b <= gbk_pkg::LEAD_HIGH && !eos) begin
                        lead_byte = b;
                        lead_held = 1'b1;
                    end else begin
                        due_chars.push_back(translate({8'h00, b}));
                    end
                end
            end
            if (due_chars.size() > before_count)
                due_chars[$].last = 1'b1;
        endfunction

        function void check_code_point(logic [15:0] code_point, logic found, logic last);
            decoded_char_t exp;
            checked++;
            if (due_chars.size() == 0) begin
                $display("%0t: unexpected code point %h found %b last %b",
                         $time, code_point, found, last);
                errors++;
                return;
            end
            exp = due_chars.pop_front();
            if (code_point !== exp.code_point || found !== exp.found || last !== exp.last) begin
                $display("%0t: mismatch expected code_point %h found %b last %b, got %h %b %b",
                         $time, exp.code_point, exp.found, exp.last, code_point, found, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // entry_index[14:0], entry_key[30:15], entry_value[46:31], data_byte[54:47], zero pad
    logic [55:0] s_tdata = '0;
    // mode[0]
    logic        s_tuser = 1'b0;
    // end_of_string
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // code_point[15:0]
    logic [15:0] m_tdata;
    // found[0]
    logic        m_tuser;
    logic        m_tlast;

    logic        no_gaps = 1'b0;

    code_point_tracker model = new;

    gbk_to_unicode_stream_decoder #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("[gbk_to_unicode_stream_decoder] ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= no_gaps || ($urandom_range(99) >= 7);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                model.accept_request(s_tuser, s_tdata[14:0], s_tdata[30:15], s_tdata[46:31],
                                     s_tdata[54:47], s_tlast);
            if (m_tvalid && m_tready)
                model.check_code_point(m_tdata, m_tuser, m_tlast);
        end
    end

    // Sorted keys: the single-byte codes first, then nearly all of 0x8000..0xFFFE.
    function automatic logic [15:0] key_of(int unsigned i);
        if (i < 128)
            return 16'(32'h80 + i);
        return 16'(32'h8000 + (i - 128) + (i - 128) / 256);
    endfunction

    task automatic send_item(input logic mode, input logic [14:0] idx, input logic [15:0] key,
                             input logic [15:0] value, input logic [7:0] b, input logic eos);
        while (!no_gaps && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, b, value, key, idx};
        s_tuser <= mode;
        s_tlast <= eos;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eos);
        send_item(gbk_pkg::MODE_DATA, 15'($urandom), 16'($urandom), 16'($urandom), b, eos);
    endtask

    task automatic send_load(input logic [14:0] idx, input logic [15:0] key,
                             input logic [15:0] value);
        send_item(gbk_pkg::MODE_LOAD, idx, key, value, 8'($urandom), 1'($urandom));
    endtask

    task automatic reg_access(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ENTRIES_ADDR;
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_entries(input logic [15:0] value);
        logic [31:0] rdata;
        reg_access(1'b1, {16'h0000, value}, rdata);
        model.set_entries(value);
        reg_access(1'b0, '0, rdata);
        if (rdata[15:0] !== value) begin
            $display("%0t: entries_in_use read back expected %h, got %h", $time, value, rdata);
            model.errors++;
        end
    endtask

    // Hold off until every due code point is out, then let a trailing request finish.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (model.due_chars.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic run_directed();
        send_load(15'd0, 16'h0000, 16'h0000);
        send_load(15'd32767, 16'hFFFF, 16'hFFFF);
        send_byte(8'h41, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hFE, 1'b0);
        // lead followed by a byte that cannot trail it
        send_byte(8'h81, 1'b0);
        send_byte(8'h3F, 1'b0);
        send_byte(8'hB0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hC1, 1'b1);
        // zero byte mid-string: flush the lead, drop the rest
        send_byte(8'hD2, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h66, 1'b1);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h90, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h41, 1'b1);
    endtask

    task automatic send_text();
        int unsigned len;
        int unsigned kind;
        int unsigned idx;
        logic [7:0]  lead;
        logic        eos;
        len = $urandom_range(12, 1);
        for (int i = 0; i < len; i++) begin
            eos = (i == len - 1);
            kind = $urandom_range(99);
            lead = 8'($urandom_range(8'hFE, 8'h81));
            if (kind < 40) begin
                send_byte(8'($urandom_range(127, 1)), eos);
            end else if (kind < 80) begin
                send_byte(lead, 1'b0);
                send_byte(8'($urandom_range(8'hFE, 8'h40)), eos);
            end else if (kind < 85) begin
                if (eos) begin
                    send_byte(lead, 1'b1);
                end else begin
                    send_byte(lead, 1'b0);
                    case ($urandom_range(2))
                        0: send_byte(8'($urandom_range(8'h3F, 1)), eos);
                        1: send_byte(8'hFF, eos);
                        default: send_byte(8'h00, eos);
                    endcase
                end
            end else if (kind < 90) begin
                send_byte($urandom_range(1) ? 8'hFF : 8'h80, eos);
            end else if (kind < 93) begin
                send_byte(8'h00, eos);
            end else if (kind < 97) begin
                // rewrite an entry; now and then with a key out of order
                idx = $urandom_range(TABLE_DEPTH - 1);
                if ($urandom_range(19) == 0)
                    send_load(15'(idx), 16'($urandom), 16'($urandom));
                else
                    send_load(15'(idx), key_of(idx), 16'($urandom));
            end else begin
                send_byte(8'($urandom), eos);
            end
        end
    endtask

    initial begin
        logic [31:0] rdata;
        logic [15:0] phase_entries [SETTING_COUNT];
        int unsigned base;
        phase_entries = '{gbk_pkg::ENTRIES_RESET, 16'd32768, 16'd0, 16'd1,
                          16'($urandom_range(400, 3)), 16'd2, 16'd32767,
                          16'($urandom_range(32768, 1000))};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        reg_access(1'b0, '0, rdata);
        if (rdata[15:0] !== gbk_pkg::ENTRIES_RESET) begin
            $display("%0t: entries_in_use after reset expected %h, got %h",
                     $time, gbk_pkg::ENTRIES_RESET, rdata);
            model.errors++;
        end
        // fill the whole table so that no search can touch an unwritten entry
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_load(15'(i), key_of(i), 16'($urandom));
        base = model.live_items;
        for (int p = 0; p < SETTING_COUNT; p++) begin
            if (p > 0) begin
                wait_idle();
                program_entries(phase_entries[p]);
            end
            no_gaps <= (p == 3);
            if (p == 0)
                run_directed();
            while (model.live_items < base + (p + 1) * ITEMS_PER_SETTING)
                send_text();
        end
        wait_idle();
        $display("checked %0d code points (%0d table hits, %0d replacements)",
                 model.checked, model.hits, model.misses);
        $display("from %0d requests after the table fill, across %0d table sizes",
                 model.live_items - base, SETTING_COUNT);
        if (model.errors == 0)
            $display("[gbk_to_unicode_stream_decoder] OK");
        else
            $display("[gbk_to_unicode_stream_decoder] ERROR");
        $finish;
    end

endmodule

// File: gbk_to_unicode_stream_decoder.f
hw/rtl/gbk_pkg.sv
hw/rtl/gbk_table_ram.sv
hw/rtl/gbk_search.sv
hw/rtl/gbk_to_unicode_stream_decoder.sv
bench/tb.sv
